// ===== rtl/core/ptt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared sizes, codes and types of the periodic task timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

   localparam int SLOTS    = 8;
   localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int MAX_RES  = 8;
   localparam int FIRE_W   = $clog2(MAX_RES + 1);
   localparam int BUF_W    = $clog2(MAX_RES);

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NULL    = 3'd1,
      ST_FULL    = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_STARTED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_WALK   = 4'b0010,
      S_FINISH = 4'b0100,
      S_EMIT   = 4'b1000
   } state_type;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [7:0]  consumer;
      logic [15:0] period;
      logic [15:0] count;
      logic        periodic;
   } slot_type;

endpackage

// ===== rtl/core/periodic_task_timer_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_timer_table_unit
// Timer slot table in a synchronous ram; ticks, starts and stops
// walk the table one slot per cycle and fire beats are queued, then sent.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                               tuser  tlast
//  req      in   task_id, consumer, delay_ticks, periodic, pad    cmd    -
//  rsp      out  status, fired_task_id, fired_consumer,           kind   last
//                fired_slot, timer_running, pad
//
//  a tick, a start or a stop that passes its early checks walks all SLOTS
//  entries through the ram read port, then sends its result beats. rejected
//  commands send their beat without a walk. one item is in flight at a time;
//  req_tready is low until the last rsp beat is taken. reset clears the
//  state, the used bits, the used count and the walk flags only; a stalled
//  rsp beat simply holds.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // task_id, consumer, delay_ticks, periodic, zero pad
   input  logic [1:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status, fired_task_id, fired_consumer, fired_slot,
                                    // timer_running, zero pad
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast
);

   localparam logic [ptt_pkg::IDX_W-1:0] LAST_IDX = ptt_pkg::IDX_W'(ptt_pkg::SLOTS - 1);

   // slot ram
   ptt_pkg::slot_type mem [ptt_pkg::SLOTS];
   ptt_pkg::slot_type rd_data_ff;
   logic                       wr_en;
   logic [ptt_pkg::IDX_W-1:0]  wr_addr;
   ptt_pkg::slot_type          wr_data;

   // control
   ptt_pkg::state_type         state_ff, state_in;
   logic [ptt_pkg::SLOTS-1:0]  used_ff, used_in;
   logic [ptt_pkg::CNT_W-1:0]  used_cnt_ff, used_cnt_in;
   logic                       issue_ff, issue_in;
   logic [ptt_pkg::IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic                       proc_vld_ff, proc_vld_in;
   logic [ptt_pkg::IDX_W-1:0]  proc_idx_ff, proc_idx_in;
   logic                       match_ff, match_in;
   logic [ptt_pkg::IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic                       free_ff, free_in;
   logic [ptt_pkg::IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [ptt_pkg::FIRE_W-1:0] fire_n_ff, fire_n_in;
   logic [ptt_pkg::BUF_W-1:0]  emit_idx_ff, emit_idx_in;

   // latched request and command status
   logic [1:0]          cmd_ff;
   logic [7:0]          tid_ff;
   logic [7:0]          cons_ff;
   logic [15:0]         delay_ff;
   logic                per_ff;
   ptt_pkg::status_type status_ff, status_in;

   // fire beat queue
   logic [7:0] fq_tid_ff  [ptt_pkg::MAX_RES];
   logic [7:0] fq_cons_ff [ptt_pkg::MAX_RES];
   logic [2:0] fq_slot_ff [ptt_pkg::MAX_RES];

   logic        req_acc, rsp_acc;
   logic [1:0]  req_cmd;
   logic [7:0]  req_tid, req_cons;
   logic        used_now, key_hit, fire, push;
   logic [15:0] cnt_inc;
   logic        is_last;

   assign req_cmd  = req_tuser;
   assign req_tid  = req_tdata[7:0];
   assign req_cons = req_tdata[15:8];

   assign req_tready = (state_ff == ptt_pkg::S_IDLE) && !reset;
   assign rsp_tvalid = (state_ff == ptt_pkg::S_EMIT);
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_acc    = rsp_tvalid & rsp_tready;

   // process stage: the slot read in the previous cycle
   assign used_now = used_ff[proc_idx_ff];
   assign key_hit  = used_now && (rd_data_ff.task_id == tid_ff) &&
                     (rd_data_ff.consumer == cons_ff);
   assign cnt_inc  = rd_data_ff.count + 16'd1;
   assign fire     = proc_vld_ff && (cmd_ff == ptt_pkg::CMD_TICK) && used_now &&
                     (cnt_inc >= rd_data_ff.period);
   assign push     = fire && (fire_n_ff < ptt_pkg::FIRE_W'(ptt_pkg::MAX_RES));

   assign is_last  = (fire_n_ff == '0) ||
                     (ptt_pkg::FIRE_W'(emit_idx_ff) == fire_n_ff - ptt_pkg::FIRE_W'(1));

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      used_cnt_in  = used_cnt_ff;
      issue_in     = 1'b0;
      rd_idx_in    = rd_idx_ff;
      proc_vld_in  = 1'b0;
      proc_idx_in  = rd_idx_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      fire_n_in    = fire_n_ff;
      emit_idx_in  = emit_idx_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = proc_idx_ff;
      wr_data      = rd_data_ff;

      case (state_ff)
         ptt_pkg::S_IDLE: begin
            if (req_acc) begin
               match_in    = 1'b0;
               free_in     = 1'b0;
               fire_n_in   = '0;
               emit_idx_in = '0;
               status_in   = ptt_pkg::ST_OK;
               rd_idx_in   = '0;
               case (req_cmd)
                  ptt_pkg::CMD_TICK: begin
                     issue_in = 1'b1;
                     state_in = ptt_pkg::S_WALK;
                  end
                  ptt_pkg::CMD_START: begin
                     // full check comes ahead of the null check
                     if (used_cnt_ff >= ptt_pkg::CNT_W'(ptt_pkg::SLOTS)) begin
                        status_in = ptt_pkg::ST_FULL;
                        state_in  = ptt_pkg::S_EMIT;
                     end else if (req_cons == 8'd0) begin
                        status_in = ptt_pkg::ST_NULL;
                        state_in  = ptt_pkg::S_EMIT;
                     end else begin
                        issue_in = 1'b1;
                        state_in = ptt_pkg::S_WALK;
                     end
                  end
                  ptt_pkg::CMD_STOP: begin
                     if (req_cons == 8'd0) begin
                        status_in = ptt_pkg::ST_NULL;
                        state_in  = ptt_pkg::S_EMIT;
                     end else if (used_cnt_ff == '0) begin
                        status_in = ptt_pkg::ST_EMPTY;
                        state_in  = ptt_pkg::S_EMIT;
                     end else begin
                        issue_in = 1'b1;
                        state_in = ptt_pkg::S_WALK;
                     end
                  end
                  default: begin
                     state_in = ptt_pkg::S_EMIT;
                  end
               endcase
            end
         end

         ptt_pkg::S_WALK: begin
            if (issue_ff) begin
               proc_vld_in = 1'b1;
               issue_in    = (rd_idx_ff != LAST_IDX);
               rd_idx_in   = rd_idx_ff + ptt_pkg::IDX_W'(1);
            end
            if (proc_vld_ff) begin
               if (cmd_ff == ptt_pkg::CMD_TICK) begin
                  if (used_now) begin
                     wr_en         = 1'b1;
                     wr_data.count = fire ? 16'd0 : cnt_inc;
                  end
                  if (push) begin
                     fire_n_in = fire_n_ff + ptt_pkg::FIRE_W'(1);
                  end
                  if (fire && !rd_data_ff.periodic) begin
                     used_in[proc_idx_ff] = 1'b0;
                     used_cnt_in          = used_cnt_in - ptt_pkg::CNT_W'(1);
                  end
               end else begin
                  if (key_hit && !match_ff) begin
                     match_in     = 1'b1;
                     match_idx_in = proc_idx_ff;
                  end
                  if (!used_now && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = proc_idx_ff;
                  end
               end
               if (proc_idx_ff == LAST_IDX) begin
                  state_in = ptt_pkg::S_FINISH;
               end
            end
         end

         ptt_pkg::S_FINISH: begin
            state_in = ptt_pkg::S_EMIT;
            if (cmd_ff == ptt_pkg::CMD_START) begin
               if (match_ff) begin
                  status_in = ptt_pkg::ST_STARTED;
               end else if (free_ff) begin
                  wr_en                = 1'b1;
                  wr_addr              = free_idx_ff;
                  wr_data.task_id      = tid_ff;
                  wr_data.consumer     = cons_ff;
                  wr_data.period       = (delay_ff == 16'd0) ? 16'd1 : delay_ff;
                  wr_data.count        = 16'd0;
                  wr_data.periodic     = per_ff;
                  used_in[free_idx_ff] = 1'b1;
                  used_cnt_in          = used_cnt_ff + ptt_pkg::CNT_W'(1);
               end else begin
                  status_in = ptt_pkg::ST_FULL;
               end
            end else if (cmd_ff == ptt_pkg::CMD_STOP) begin
               if (match_ff) begin
                  used_in[match_idx_ff] = 1'b0;
                  used_cnt_in           = used_cnt_ff - ptt_pkg::CNT_W'(1);
               end
            end
         end

         ptt_pkg::S_EMIT: begin
            if (rsp_acc) begin
               if (is_last) begin
                  state_in = ptt_pkg::S_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + ptt_pkg::BUF_W'(1);
               end
            end
         end

         default: begin
            state_in = ptt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ptt_pkg::S_IDLE;
         used_ff     <= '0;
         used_cnt_ff <= '0;
         issue_ff    <= 1'b0;
         proc_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         used_cnt_ff <= used_cnt_in;
         issue_ff    <= issue_in;
         proc_vld_ff <= proc_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      proc_idx_ff  <= proc_idx_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      fire_n_ff    <= fire_n_in;
      emit_idx_ff  <= emit_idx_in;
      status_ff    <= status_in;
      if (req_acc) begin
         cmd_ff   <= req_cmd;
         tid_ff   <= req_tid;
         cons_ff  <= req_cons;
         delay_ff <= req_tdata[31:16];
         per_ff   <= req_tdata[32];
      end
   end

   // slot ram: one read port, one write port
   always_ff @(posedge clock) begin
      if (issue_ff) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fq_tid_ff[fire_n_ff[ptt_pkg::BUF_W-1:0]]  <= rd_data_ff.task_id;
         fq_cons_ff[fire_n_ff[ptt_pkg::BUF_W-1:0]] <= rd_data_ff.consumer;
         fq_slot_ff[fire_n_ff[ptt_pkg::BUF_W-1:0]] <= 3'(proc_idx_ff);
      end
   end

   // command beats and empty ticks carry zero fire fields
   always_comb begin
      rsp_tdata = '0;
      rsp_tuser = 1'b0;
      if (fire_n_ff != '0) begin
         rsp_tuser         = 1'b1;
         rsp_tdata[2:0]    = ptt_pkg::ST_OK;
         rsp_tdata[10:3]   = fq_tid_ff[emit_idx_ff];
         rsp_tdata[18:11]  = fq_cons_ff[emit_idx_ff];
         rsp_tdata[21:19]  = fq_slot_ff[emit_idx_ff];
      end else begin
         rsp_tdata[2:0]    = status_ff;
      end
      rsp_tdata[22] = (used_cnt_ff != '0);
   end

   assign rsp_tlast = is_last;

endmodule
